>>> rtl/core/lpht_pkg.sv
// Shared types and constants for the linear-probe hash table.
`default_nettype none
package lpht_pkg;

   localparam int unsigned KEY_IN_WIDTH = 16;
   localparam int unsigned SLOT_WIDTH = 4;
   localparam int unsigned MOD_WIDTH = 5;

   localparam logic [MOD_WIDTH-1:0] MOD_RESET = 5'd13;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   typedef struct packed {
      logic                    kind;
      logic [KEY_IN_WIDTH-1:0] key;
   } req_type;

   typedef struct packed {
      logic                  ok;
      logic [SLOT_WIDTH-1:0] slot;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/core/lpht_mod_unit.sv
// Bit-serial restoring remainder unit: key modulo the configured divisor.
`default_nettype none
module lpht_mod_unit
   import lpht_pkg::*;
#(
   parameter int unsigned KEY_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [KEY_WIDTH-1:0] dividend,
   input  wire logic [MOD_WIDTH-1:0] divisor,
   output logic                      done,
   output logic [MOD_WIDTH-1:0]      remainder
);

   localparam int unsigned SW = $clog2(KEY_WIDTH);
   localparam logic [SW-1:0] LAST_STEP = SW'(KEY_WIDTH - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SW-1:0]        step_ff, step_in;
   logic [KEY_WIDTH-1:0] shift_ff, shift_in;
   logic [MOD_WIDTH-1:0] div_ff, div_in;
   logic [MOD_WIDTH-1:0] rem_ff, rem_in;
   logic [MOD_WIDTH:0]   trial;

   // The partial remainder stays below the divisor, so the trial fits one extra bit.
   assign trial = {rem_ff, shift_ff[KEY_WIDTH-1]};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         shift_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[KEY_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = MOD_WIDTH'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[MOD_WIDTH-1:0];
         end
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

>>> rtl/core/lpht_slot_mem.sv
// Slot memory: one write port and one registered read port.
`default_nettype none
module lpht_slot_mem #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 17
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/linear_probe_hash_table.sv
// Linear-probe hash table: after reset a clearing pass writes every slot, with req_ready low.
// Per word: accept, remainder in the serial remainder unit, wrap reduction into the table,
// then probes, each a registered slot memory read followed by a compare, up to TABLE_DEPTH
// probes, and finally the result is posted once the output register is free.
// One word is in flight at a time; the memory read port sets the probe rate.
// Reset is synchronous and active high; the modulus register resets to 13.
`default_nettype none
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 16,
   parameter int unsigned KEY_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [MOD_WIDTH-1:0] csr_data
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned MW = KEY_WIDTH + 1;
   localparam int unsigned RW = (CW > MOD_WIDTH) ? CW : MOD_WIDTH;
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
   localparam logic [CW-1:0] LAST_PROBE = CW'(TABLE_DEPTH - 1);
   localparam logic [RW-1:0] DEPTH_CMP = RW'(TABLE_DEPTH);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_REDUCE = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_CHECK  = 3'd5;
   localparam logic [2:0] ST_RESULT = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [MOD_WIDTH-1:0] home_ff, home_in;
   logic [MOD_WIDTH-1:0] mod_ff, mod_in;
   logic                 kind_ff, kind_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 ok_ff, ok_in;
   logic                 wr_ff, wr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 req_fire;
   logic                 out_free;
   logic                 div_done;
   logic [MOD_WIDTH-1:0] div_rem;
   logic [MOD_WIDTH-1:0] divisor;
   logic [KEY_WIDTH-1:0] req_key;
   logic                 mem_wr_en;
   logic [MW-1:0]        mem_wr_data;
   logic                 mem_rd_en;
   logic [MW-1:0]        mem_rd_data;
   logic                 rd_valid;
   logic [KEY_WIDTH-1:0] rd_key;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign req_key   = KEY_WIDTH'(req_data.key);
   // A modulus of zero behaves as one.
   assign divisor   = (mod_ff == '0) ? MOD_WIDTH'(1) : mod_ff;
   assign rd_valid  = mem_rd_data[KEY_WIDTH];
   assign rd_key    = mem_rd_data[KEY_WIDTH-1:0];

   lpht_mod_unit #(
      .KEY_WIDTH(KEY_WIDTH)
   ) u_mod_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .dividend (req_key),
      .divisor  (divisor),
      .done     (div_done),
      .remainder(div_rem)
   );

   lpht_slot_mem #(
      .DEPTH(TABLE_DEPTH),
      .WIDTH(MW)
   ) u_slot_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(addr_ff),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(addr_ff),
      .rd_data(mem_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      home_in      = home_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      ok_in        = ok_ff;
      wr_in        = wr_ff;
      mem_wr_en    = 1'b0;
      mem_wr_data  = {1'b1, key_ff};
      mem_rd_en    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mod_in       = (csr_valid && csr_ready) ? csr_data : mod_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = '0;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = req_data.kind;
               key_in   = req_key;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               home_in  = div_rem;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            // Fold the home slot into the table when the modulus exceeds the depth.
            if (RW'(home_ff) >= DEPTH_CMP) begin
               home_in = home_ff - MOD_WIDTH'(TABLE_DEPTH);
            end else begin
               addr_in  = AW'(home_ff);
               cnt_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (!rd_valid) begin
               ok_in    = (kind_ff == KIND_INSERT);
               wr_in    = (kind_ff == KIND_INSERT);
               state_in = ST_RESULT;
            end else if (rd_key == key_ff) begin
               ok_in    = 1'b1;
               wr_in    = 1'b0;
               state_in = ST_RESULT;
            end else if (cnt_ff == LAST_PROBE) begin
               ok_in    = 1'b0;
               wr_in    = 1'b0;
               state_in = ST_RESULT;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               addr_in  = (addr_ff == LAST_ADDR) ? '0 : addr_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               mem_wr_en        = wr_ff;
               rsp_valid_in     = 1'b1;
               rsp_data_in.ok   = ok_ff;
               rsp_data_in.slot = ok_ff ? SLOT_WIDTH'(addr_ff) : '0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         mod_ff       <= MOD_RESET;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         mod_ff       <= mod_in;
      end
      cnt_ff      <= cnt_in;
      home_ff     <= home_in;
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      ok_ff       <= ok_in;
      wr_ff       <= wr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/lpht_checker.sv
// Port-level checker for the hash table, bound to the top level.
`default_nettype none
module lpht_checker
   import lpht_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // A stalled result word must hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // A miss or a full table never reports a slot.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.slot == '0)
      else $error("failed result carries a nonzero slot");

   // Each request word is worked through before the next is taken, so ready drops right after acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on back-to-back cycles");

   // The clearing pass holds off requests and no result is pending after reset.
   assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block not quiet after reset");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
`default_nettype wire
